>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bba_pkg.sv
package bba_pkg;

  localparam int WordW = 32;
  localparam int BitW  = 5;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_INIT   = 2'd2,
    OP_DEINIT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_READY   = 3'd1,
    ST_INVALID_ARG = 3'd2,
    ST_NO_MEMORY   = 3'd3,
    ST_BAD_STATE   = 3'd4
  } status_e;

  function automatic logic [BitW-1:0] lowest_zero(word_t w);
    logic [BitW-1:0] r;
    r = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = BitW'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/bitmap_block_allocator.sv
// First-fit allocator of BLOCK_COUNT fixed blocks of BLOCK_BYTES bytes starting at pool_base.
// The used bitmap sits in a memory of 32-bit words, with one full bit per word in a summary
// register and one written bit per word so that init clears the pool without a sweep. The
// block takes one transaction at a time: allocate registers its result after a memory read,
// a modify and write back and an address multiply; free after a range check, a two-stage
// reciprocal multiply for the block index, a memory read and a write back; a free that fails
// the range check after the check alone; init, deinit and the other errors with no step. The
// next transaction is taken the cycle after the result is registered, while that result may
// still be stalled at the output; a result that is still stalled holds the next one in its
// finish state until it drains. The user must write pool_base through cfg_we_i/cfg_wdata_i
// only while no transaction is in flight; the block itself does not enforce this.
module bitmap_block_allocator #(
  parameter int BLOCK_BYTES = 32,
  parameter int BLOCK_COUNT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] block_address_o,
  output logic        ready_res_o,
  output logic [15:0] free_bytes_o,
  output logic [15:0] used_bytes_o
);
  import bba_pkg::*;

  `include "assert_macros.svh"

  localparam longint PoolBytes = longint'(BLOCK_BYTES) * longint'(BLOCK_COUNT);
  localparam int WordCount = (BLOCK_COUNT + WordW - 1) / WordW;
  localparam int WAddrW    = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int BlkW      = WAddrW + BitW;
  localparam int IdxW      = $clog2(BLOCK_COUNT);
  localparam int OfsW      = $clog2(PoolBytes);
  localparam int CntW      = $clog2(BLOCK_COUNT + 1);
  localparam int LastBits  = BLOCK_COUNT - (WordCount - 1) * WordW;
  localparam logic [WordW:0] LastOne = (WordW + 1)'(1) << LastBits;
  localparam word_t PadMask = ~(LastOne[WordW-1:0] - word_t'(1));
  localparam logic [WAddrW-1:0] LastWord = WAddrW'(WordCount - 1);
  localparam logic [32:0] PoolL = 33'(PoolBytes);
  localparam logic [31:0] Pool32 = 32'(PoolBytes);
  localparam logic [31:0] BlockBytes32 = 32'(BLOCK_BYTES);
  localparam logic [32:0] RstBase = 33'h0_2000_0000;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_DIV  = 6'b000100,
    S_MOD  = 6'b001000,
    S_ADR  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic ready_q, ready_d;
  logic [WordCount-1:0] written_q, written_d;
  logic [WordCount-1:0] summary_q, summary_d;
  logic [CntW-1:0] used_cnt_q, used_cnt_d;
  logic out_valid_q, out_valid_d;
  logic [31:0] pool_base_q, pool_base_d;

  op_e op_q, op_d;
  logic [31:0] addr_q, addr_d;
  logic [WAddrW-1:0] word_q, word_d;
  logic [BlkW-1:0] blk_idx_q, blk_idx_d;
  logic [31:0] blk_prod_q, blk_prod_d;
  status_e res_status_q, res_status_d;
  logic res_alloc_q, res_alloc_d;
  logic [2:0] status_q, status_d;
  logic [31:0] blk_addr_q, blk_addr_d;
  logic res_ready_q, res_ready_d;
  logic [15:0] free_bytes_q, free_bytes_d;
  logic [15:0] used_bytes_q, used_bytes_d;

  logic in_accept;
  op_e in_op;
  logic [WAddrW-1:0] alloc_word;
  logic pool_full;
  logic [32:0] offset;
  logic free_bad;
  logic div_start, div_valid;
  logic [IdxW-1:0] div_idx;
  logic [BlkW-1:0] div_blk;
  logic ram_we, ram_re;
  logic [WAddrW-1:0] ram_raddr;
  word_t ram_rdata, cur_word, new_word;
  logic [BitW-1:0] bit_sel;
  logic [31:0] used32, free32;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_op      = op_e'(operation_i);
  assign pool_full  = &summary_q;

  always_comb begin
    alloc_word = '0;
    for (int i = WordCount - 1; i >= 0; i--) begin
      if (!summary_q[i]) begin
        alloc_word = WAddrW'(i);
      end
    end
  end

  assign offset    = {1'b0, addr_q} - {1'b0, pool_base_q};
  assign free_bad  = (addr_q == 32'd0) || offset[32] || (offset >= PoolL);
  assign div_start = (state_q == S_CHK) && !free_bad;
  assign div_blk   = BlkW'(div_idx);

  bba_index_div #(
    .OfsW       (OfsW),
    .IdxW       (IdxW),
    .BlockBytes (BLOCK_BYTES)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_start),
    .offset_i (offset[OfsW-1:0]),
    .valid_o  (div_valid),
    .idx_o    (div_idx)
  );

  assign cur_word = written_q[word_q] ? ram_rdata : ((word_q == LastWord) ? PadMask : '0);
  assign used32   = 32'(used_cnt_q) * BlockBytes32;
  assign free32   = Pool32 - used32;

  always_comb begin
    state_d      = state_q;
    ready_d      = ready_q;
    written_d    = written_q;
    summary_d    = summary_q;
    used_cnt_d   = used_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    pool_base_d  = cfg_we_i ? cfg_wdata_i : pool_base_q;
    op_d         = op_q;
    addr_d       = addr_q;
    word_d       = word_q;
    blk_idx_d    = blk_idx_q;
    blk_prod_d   = blk_prod_q;
    res_status_d = res_status_q;
    res_alloc_d  = res_alloc_q;
    status_d     = status_q;
    blk_addr_d   = blk_addr_q;
    res_ready_d  = res_ready_q;
    free_bytes_d = free_bytes_q;
    used_bytes_d = used_bytes_q;
    ram_re       = 1'b0;
    ram_raddr    = alloc_word;
    ram_we       = 1'b0;
    new_word     = cur_word;
    bit_sel      = blk_idx_q[BitW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d        = in_op;
          addr_d      = address_i;
          res_alloc_d = 1'b0;
          res_status_d = ST_OK;
          state_d     = S_FIN;
          if (in_op == OP_INIT) begin
            if (ready_q) begin
              res_status_d = ST_BAD_STATE;
            end else begin
              ready_d    = 1'b1;
              written_d  = '0;
              summary_d  = '0;
              used_cnt_d = '0;
            end
          end else if (!ready_q) begin
            res_status_d = ST_NOT_READY;
          end else if (in_op == OP_DEINIT) begin
            ready_d = 1'b0;
          end else if (in_op == OP_FREE) begin
            state_d = S_CHK;
          end else if (pool_full) begin
            res_status_d = ST_NO_MEMORY;
          end else begin
            ram_re  = 1'b1;
            word_d  = alloc_word;
            state_d = S_MOD;
          end
        end
      end
      S_CHK: begin
        if (free_bad) begin
          res_status_d = ST_INVALID_ARG;
          state_d      = S_FIN;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_valid) begin
          ram_re    = 1'b1;
          ram_raddr = div_blk[BlkW-1:BitW];
          word_d    = div_blk[BlkW-1:BitW];
          blk_idx_d = div_blk;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        ram_we = 1'b1;
        written_d[word_q] = 1'b1;
        if (op_q == OP_ALLOC) begin
          bit_sel = lowest_zero(cur_word);
          new_word[bit_sel] = 1'b1;
          used_cnt_d  = used_cnt_q + CntW'(1);
          blk_idx_d   = {word_q, bit_sel};
          res_alloc_d = 1'b1;
          state_d     = S_ADR;
        end else begin
          new_word[bit_sel] = 1'b0;
          if (cur_word[bit_sel]) begin
            used_cnt_d = used_cnt_q - CntW'(1);
          end
          state_d = S_FIN;
        end
        summary_d[word_q] = &new_word;
      end
      S_ADR: begin
        blk_prod_d = 32'(blk_idx_q) * BlockBytes32;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          status_d     = res_status_q;
          blk_addr_d   = res_alloc_q ? (pool_base_q + blk_prod_q) : 32'd0;
          res_ready_d  = ready_q;
          used_bytes_d = (|used32[31:16]) ? 16'hFFFF : used32[15:0];
          free_bytes_d = (|free32[31:16]) ? 16'hFFFF : free32[15:0];
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  bba_bitmap_ram #(
    .Depth (WordCount),
    .AddrW (WAddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (new_word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      written_q   <= '0;
      summary_q   <= '0;
      used_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      pool_base_q <= RstBase[31:0];
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      written_q   <= written_d;
      summary_q   <= summary_d;
      used_cnt_q  <= used_cnt_d;
      out_valid_q <= out_valid_d;
      pool_base_q <= pool_base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    addr_q       <= addr_d;
    word_q       <= word_d;
    blk_idx_q    <= blk_idx_d;
    blk_prod_q   <= blk_prod_d;
    res_status_q <= res_status_d;
    res_alloc_q  <= res_alloc_d;
    status_q     <= status_d;
    blk_addr_q   <= blk_addr_d;
    res_ready_q  <= res_ready_d;
    free_bytes_q <= free_bytes_d;
    used_bytes_q <= used_bytes_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign block_address_o = blk_addr_q;
  assign ready_res_o     = res_ready_q;
  assign free_bytes_o    = free_bytes_q;
  assign used_bytes_o    = used_bytes_q;

  `ASSERT_ALWAYS(a_used_le_count, used_cnt_q <= CntW'(BLOCK_COUNT), "used count past pool size")
  `ASSERT_NEXT(a_alloc_reads, in_accept && ready_q && in_op == OP_ALLOC && !pool_full, state_q == S_MOD, "allocate did not go to modify")
  `ASSERT_IMPL(a_out_from_fin, $rose(out_valid_o), $past(state_q == S_FIN), "result not from finish state")
  `ASSERT_IMPL(a_mod_written, state_q == S_MOD, ready_q, "bitmap write while not ready")

endmodule

>>> rtl/bba_bitmap_ram.sv
module bba_bitmap_ram #(
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  bba_pkg::word_t     wdata_i,
  input  logic               re_i,
  input  logic [AddrW-1:0]   raddr_i,
  output bba_pkg::word_t     rdata_o
);
  import bba_pkg::*;

  word_t mem_q [Depth];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bba_index_div.sv
module bba_index_div #(
  parameter int OfsW       = 15,
  parameter int IdxW       = 10,
  parameter int BlockBytes = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [OfsW-1:0] offset_i,
  output logic            valid_o,
  output logic [IdxW-1:0] idx_o
);
  import bba_pkg::*;

  // offset / BlockBytes as offset * ceil(2^ShR / BlockBytes) >> ShR, exact for OfsW-bit offsets
  localparam int ShR = OfsW + $clog2(BlockBytes);
  localparam longint unsigned Recip =
    ((longint'(1) << ShR) + longint'(BlockBytes) - 1) / longint'(BlockBytes);
  localparam int RecipW = OfsW + 2;
  localparam int ProdW  = OfsW + RecipW;
  localparam logic [RecipW-1:0] RecipL = RecipW'(Recip);

  logic            v1_q, v1_d, v2_q, v2_d;
  logic [OfsW-1:0] offset_q, offset_d;
  logic [ProdW-1:0] prod_q, prod_d;

  always_comb begin
    v1_d     = valid_i;
    v2_d     = v1_q;
    offset_d = valid_i ? offset_i : offset_q;
    prod_d   = v1_q ? (ProdW'(offset_q) * ProdW'(RecipL)) : prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q <= offset_d;
    prod_q   <= prod_d;
  end

  assign valid_o = v2_q;
  assign idx_o   = prod_q[ShR +: IdxW];

endmodule
